### hw/rtl/value_noise_tile_classifier_defines.svh
// Assertion macros used by the checker file.
`ifndef VALUE_NOISE_TILE_CLASSIFIER_DEFINES_SVH
`define VALUE_NOISE_TILE_CLASSIFIER_DEFINES_SVH

// Assert that an antecedent implies a consequent on the next edge.
`define VNTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Assert that a condition holds at every edge outside reset.
`define VNTC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Assert that an antecedent implies a consequent a fixed number of edges later.
`define VNTC_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

### hw/rtl/vntc_pkg.sv
`default_nettype none
package vntc_pkg;
   localparam int CoordBitsDefault    = 24;
   localparam int FractionBitsDefault = 24;
   localparam int NoiseBits           = 27;
   localparam logic [31:0] Oct2Div    = 32'd2927419459;
   localparam logic [31:0] Oct2Half   = 32'd1463709729;

   typedef struct packed {
      logic signed [23:0] coord_x;
      logic signed [23:0] coord_y;
   } req_word_type;

   typedef struct packed {
      logic signed [26:0] noise_value;
      logic               is_wall;
   } rsp_word_type;
endpackage
`default_nettype wire

### hw/rtl/value_noise_tile_classifier.sv
`default_nettype none
// Two-octave value-noise tile classifier. Give one coordinate word per cycle by
// raising start while busy is low; busy is never raised, so every cycle may
// carry a word. Each word yields one result word on rsp_* marked by done, in
// order: done is high for one cycle, while the result register holds that word.
// The receiver cannot stall: sample done every cycle. Latency is set by the hash
// pipeline (three dependent multiplies plus the reciprocal product) and the
// smoothing tree.
module value_noise_tile_classifier
   import vntc_pkg::*;
#(
   parameter int COORD_BITS    = CoordBitsDefault,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_word,
   output logic              done,
   output rsp_word_type      rsp_word
);
   localparam int VB   = FRACTION_BITS + 3;
   // Register stages from the accepting edge to the result register.
   localparam int Lat  = 7;
   localparam int SumB = VB + 5;

   logic [31:0] x, y, x2, y2;
   logic signed [VB-1:0] v1 [9];
   logic signed [VB-1:0] v2 [9];
   logic [Lat:0] vld_ff;
   logic signed [SumB-1:0] s1_ff, s2_ff;
   logic signed [SumB+1:0] tot;
   logic signed [NoiseBits-1:0] sat_in;
   rsp_word_type rsp_ff;

   assign busy = 1'b0;

   // Sign-extend the coordinates from the top coordinate bit.
   always_comb begin
      x  = 32'($signed(req_word.coord_x[COORD_BITS-1:0]));
      y  = 32'($signed(req_word.coord_y[COORD_BITS-1:0]));
      x2 = x << 1;
      y2 = y << 1;
   end

   for (genvar k = 0; k < 9; k++) begin : g_pt
      localparam logic [31:0] Dx = 32'(k % 3) - 32'd1;
      localparam logic [31:0] Dy = 32'(k / 3) - 32'd1;
      vntc_lattice #(.OCTAVE(1), .FRACTION_BITS(FRACTION_BITS)) u_o1 (
         .clock(clock), .pt_x(x + Dx), .pt_y(y + Dy), .value(v1[k]));
      vntc_lattice #(.OCTAVE(2), .FRACTION_BITS(FRACTION_BITS)) u_o2 (
         .clock(clock), .pt_x(x2 + Dx), .pt_y(y2 + Dy), .value(v2[k]));
   end

   function automatic logic signed [SumB-1:0] wsum(
         input logic signed [VB-1:0] a0, a1, a2, a3, a4, a5, a6, a7, a8);
      logic signed [SumB-1:0] c, s;
      c = SumB'(a0) + SumB'(a2) + SumB'(a6) + SumB'(a8);
      s = SumB'(a1) + SumB'(a3) + SumB'(a5) + SumB'(a7);
      return c + (s <<< 1) + (SumB'(a4) <<< 2);
   endfunction

   always_ff @(posedge clock) begin
      s1_ff <= wsum(v1[0], v1[1], v1[2], v1[3], v1[4], v1[5], v1[6], v1[7], v1[8]);
      s2_ff <= wsum(v2[0], v2[1], v2[2], v2[3], v2[4], v2[5], v2[6], v2[7], v2[8]);
   end

   // Floor by 16 on each octave, double the second octave and sum, then saturate to the output field.
   always_comb begin
      tot = (SumB+2)'(s1_ff >>> 4) + ((SumB+2)'(s2_ff >>> 4) <<< 1);
      if (tot > (SumB+2)'(67108863)) begin
         sat_in = NoiseBits'(67108863);
      end else if (tot < -(SumB+2)'(67108864)) begin
         sat_in = NoiseBits'(-67108864);
      end else begin
         sat_in = tot[NoiseBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.noise_value <= sat_in;
      rsp_ff.is_wall     <= (tot <= 0);
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Lat-1:0], start};
      end
   end

   assign done     = vld_ff[Lat];
   assign rsp_word = rsp_ff;
endmodule
`default_nettype wire

### hw/rtl/vntc_lattice.sv
`default_nettype none
// Pipelined lattice hash for one point: six register stages, one point per cycle.
module vntc_lattice
   import vntc_pkg::*;
#(
   parameter int OCTAVE        = 1,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  wire logic        clock,
   input  wire logic [31:0] pt_x,
   input  wire logic [31:0] pt_y,
   output logic signed [FRACTION_BITS+2:0] value
);
   localparam logic [31:0] MulY  = (OCTAVE == 1) ? 32'd57 : 32'd13;
   localparam logic [31:0] MulA  = (OCTAVE == 1) ? 32'd15731 : 32'd6113;
   localparam logic [31:0] AddB  = (OCTAVE == 1) ? 32'd789221 : 32'd8629;
   localparam logic [31:0] AddC  = (OCTAVE == 1) ? 32'd1376312589 : 32'd4599271;
   localparam int          Shift = (OCTAVE == 1) ? 13 : 17;
   localparam logic [63:0] Recip =
      ((64'd1 << (FRACTION_BITS + 32)) + 64'(Oct2Half)) / 64'(Oct2Div);

   logic [31:0] n_ff, n_in, nn_ff, n2_ff, poly_ff, t_ff, n3_ff;
   logic [32:0] h_in;
   logic [63:0] prod_lo_ff, prod_hi_ff;
   logic [31:0] s1_ff;
   logic [FRACTION_BITS:0] scaled;

   always_comb begin
      n_in = pt_x + pt_y * MulY;
      n_in = (n_in << Shift) ^ n_in;
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      nn_ff   <= n_ff * n_ff;
      n2_ff   <= n_ff;
      poly_ff <= nn_ff * MulA + AddB;
      n3_ff   <= n2_ff;
      t_ff    <= n3_ff * poly_ff + AddC;
   end

   always_comb begin
      h_in = {t_ff[31], 3'b000, t_ff[28:0]};
   end

   // Split the reciprocal product into two partial products.
   always_ff @(posedge clock) begin
      prod_lo_ff <= 64'(h_in[15:0]) * Recip;
      prod_hi_ff <= 64'(h_in[32:16]) * Recip;
      s1_ff      <= 32'({1'b0, t_ff[30:0]} >> (30 - FRACTION_BITS));
   end

   always_comb begin
      if (OCTAVE == 1) begin
         scaled = s1_ff[FRACTION_BITS:0];
      end else begin
         scaled = (FRACTION_BITS+1)'(((prod_hi_ff << 16) + prod_lo_ff) >> 32);
      end
   end

   always_ff @(posedge clock) begin
      value <= $signed({2'b00, 1'b1, {FRACTION_BITS{1'b0}}})
             - $signed({2'b00, scaled});
   end
endmodule
`default_nettype wire

### hw/rtl/vntc_checker.sv
`default_nettype none
`include "value_noise_tile_classifier_defines.svh"
module vntc_checker
   import vntc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         done,
   input wire rsp_word_type rsp_word
);
   `VNTC_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "busy raised")
   `VNTC_ASSERT_ALWAYS(a_wall_sign, clock, reset,
      !done || (rsp_word.is_wall == (rsp_word.noise_value <= 0)), "wall flag mismatch")
   `VNTC_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 8, done, "result missing")
   `VNTC_ASSERT_ALWAYS(a_no_spurious, clock, reset, !done || $past(start, 8), "unexpected result")
endmodule
bind value_noise_tile_classifier vntc_checker u_vntc_checker (.*);
`default_nettype wire
